[rtl/core/line_edit_buffer_defines.svh]
// assertion macros for the line edit buffer
`ifndef LINE_EDIT_BUFFER_DEFINES_SVH
`define LINE_EDIT_BUFFER_DEFINES_SVH

// condition holds at every clock edge out of reset
`define LEB_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("line edit buffer invariant violated");

// consequence holds in the cycle after the antecedent
`define LEB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("line edit buffer sequencing violated");

`endif

[rtl/core/leb_pkg.sv]
// shared command codes, cell operations and types of the line edit buffer
`default_nettype none
package leb_pkg;

   localparam logic [3:0] CMD_NONE      = 4'd0;
   localparam logic [3:0] CMD_LEFT      = 4'd1;
   localparam logic [3:0] CMD_RIGHT     = 4'd2;
   localparam logic [3:0] CMD_HOME      = 4'd3;
   localparam logic [3:0] CMD_END       = 4'd4;
   localparam logic [3:0] CMD_BACKSPACE = 4'd5;
   localparam logic [3:0] CMD_DELETE    = 4'd6;
   localparam logic [3:0] CMD_INSERT    = 4'd7;
   localparam logic [3:0] CMD_APPEND    = 4'd8;
   localparam logic [3:0] CMD_CLEAR     = 4'd9;
   localparam logic [3:0] CMD_READ      = 4'd10;

   localparam logic [1:0] OP_HOLD   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_APPEND = 2'd2;
   localparam logic [1:0] OP_REMOVE = 2'd3;

   localparam logic [7:0] KEY_FIRST = 8'd32;
   localparam logic [7:0] KEY_LAST  = 8'd126;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] key;
   } cell_ctrl_type;

endpackage
`default_nettype wire

[rtl/core/leb_channels.sv]
// valid/ready channel interfaces for edit requests and edit responses
`default_nettype none
interface leb_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] cmd;
   logic [7:0] key_char;
   logic       editing_enabled;
   logic       move_cursor;
   logic [7:0] read_index;

   modport source (output valid, output cmd, output key_char, output editing_enabled,
                   output move_cursor, output read_index, input ready);
   modport sink (input valid, input cmd, input key_char, input editing_enabled,
                 input move_cursor, input read_index, output ready);
endinterface

interface leb_rsp_if;
   logic       valid;
   logic       ready;
   logic [8:0] line_length;
   logic [8:0] cursor_at;
   logic [7:0] read_char;
   logic       rejected;

   modport source (output valid, output line_length, output cursor_at, output read_char,
                   output rejected, input ready);
   modport sink (input valid, input line_length, input cursor_at, input read_char,
                 input rejected, output ready);
endinterface
`default_nettype wire

[rtl/core/leb_cell.sv]
// one character cell of the shifting line store
`default_nettype none
module leb_cell
   import leb_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CW    = 9
) (
   input  wire logic          clock,
   input  wire cell_ctrl_type ctrl,
   input  wire logic [CW-1:0] pos,
   input  wire logic [7:0]    chr_left,
   input  wire logic [7:0]    chr_right,
   output logic [7:0]         chr
);

   localparam logic [CW-1:0] IDX = CW'(INDEX);

   logic [7:0] chr_ff, chr_in;

   always_comb begin
      chr_in = chr_ff;
      case (ctrl.op)
         OP_INSERT: begin
            if (IDX > pos) chr_in = chr_left;
            else if (IDX == pos) chr_in = ctrl.key;
         end
         OP_APPEND: begin
            if (IDX == pos) chr_in = ctrl.key;
         end
         OP_REMOVE: begin
            if (IDX >= pos) chr_in = chr_right;
         end
         default: chr_in = chr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      chr_ff <= chr_in;
   end

   assign chr = chr_ff;

endmodule
`default_nettype wire

[rtl/core/leb_read_tree.sv]
// two-level registered character select for read commands
`default_nettype none
module leb_read_tree #(
   parameter int RD = 256
) (
   input  wire logic                clock,
   input  wire logic [RD-1:0][7:0]  chars,
   input  wire logic [7:0]          idx,
   output logic [7:0]               sel_char
);

   localparam int NG = (RD + 15) / 16;

   logic [NG-1:0][15:0][7:0] hit;
   logic [NG-1:0][7:0]       grp_ff, grp_in;

   for (genvar g = 0; g < NG; g++) begin : gen_grp
      for (genvar j = 0; j < 16; j++) begin : gen_elem
         if (g * 16 + j < RD) begin : gen_used
            assign hit[g][j] = (idx[3:0] == 4'(j)) ? chars[g * 16 + j] : 8'h00;
         end else begin : gen_pad
            assign hit[g][j] = 8'h00;
         end
      end
   end

   always_comb begin
      grp_in = '0;
      for (int g = 0; g < NG; g++) begin
         for (int j = 0; j < 16; j++) begin
            grp_in[g] = grp_in[g] | hit[g][j];
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
   end

   always_comb begin
      sel_char = 8'h00;
      for (int g = 0; g < NG; g++) begin
         if (idx[7:4] == 4'(g)) sel_char = sel_char | grp_ff[g];
      end
   end

endmodule
`default_nettype wire

[rtl/core/line_edit_buffer.sv]
// line edit buffer top level: command decode, cursor and length, cell row, response register
// Edit commands arrive on req_bus, one per transaction, and each gives exactly one
// response transaction on rsp_bus with the line length, cursor position, read
// character and the full-line reject flag.
// Every command but read updates the line in the cycle it is accepted; its
// response is valid on the next cycle. A read passes the registered read index,
// the registered group select over the cells and the response register before
// its response is valid.
// A new command is taken once the pending response has gone or goes in the
// same cycle, so edits sustain one per cycle and no command is taken mid-read.
// Insert, backspace and delete shift the cells from the edit position up in parallel.
// A stalled receiver holds the response register and req_bus.ready stays low
// until that response is taken.
// Reset empties the line and puts the cursor at zero; character cells are not
// cleared, which is harmless as only positions below the length are ever read.
`default_nettype none
`include "line_edit_buffer_defines.svh"
module line_edit_buffer
   import leb_pkg::*;
#(
   parameter int LINE_DEPTH = 256
) (
   input  wire logic  clock,
   input  wire logic  reset,
   leb_req_if.sink    req_bus,
   leb_rsp_if.source  rsp_bus
);

   localparam int CW = $clog2(LINE_DEPTH + 1);
   localparam int RD = (LINE_DEPTH < 256) ? LINE_DEPTH : 256;
   localparam int XW = CW + 8;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_READ_A = 2'd1;
   localparam logic [1:0] ST_READ_B = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] cursor_ff, cursor_in;
   logic [7:0]    ridx_ff, ridx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [8:0]    rsp_len_ff, rsp_cur_ff;
   logic [7:0]    rsp_char_ff, rsp_char_in;
   logic          rsp_rej_ff;

   logic                  req_accept;
   logic                  load;
   logic                  rej;
   logic                  printable;
   logic                  full;
   logic                  read_hit;
   logic [7:0]            sel_char;
   cell_ctrl_type         ctrl;
   logic [CW-1:0]         pos;
   logic [LINE_DEPTH-1:0][7:0] chars;

   assign req_bus.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign printable     = (req_bus.key_char >= KEY_FIRST) && (req_bus.key_char <= KEY_LAST);
   assign full          = (count_ff >= CW'(LINE_DEPTH));
   assign read_hit      = XW'(ridx_ff) < XW'(count_ff);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      cursor_in = cursor_ff;
      ridx_in   = ridx_ff;
      ctrl.op   = OP_HOLD;
      ctrl.key  = req_bus.key_char;
      pos       = cursor_ff;
      rej       = 1'b0;
      load      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               load = 1'b1;
               unique case (req_bus.cmd)
                  CMD_LEFT: begin
                     if (req_bus.editing_enabled && cursor_ff != '0)
                        cursor_in = cursor_ff - CW'(1);
                  end
                  CMD_RIGHT: begin
                     if (req_bus.editing_enabled && cursor_ff < count_ff)
                        cursor_in = cursor_ff + CW'(1);
                  end
                  CMD_HOME: cursor_in = '0;
                  CMD_END:  cursor_in = count_ff;
                  CMD_BACKSPACE: begin
                     if (req_bus.editing_enabled && cursor_ff != '0) begin
                        cursor_in = cursor_ff - CW'(1);
                        pos       = cursor_ff - CW'(1);
                        ctrl.op   = OP_REMOVE;
                        count_in  = count_ff - CW'(1);
                     end
                  end
                  CMD_DELETE: begin
                     if (req_bus.editing_enabled && cursor_ff < count_ff) begin
                        ctrl.op  = OP_REMOVE;
                        count_in = count_ff - CW'(1);
                     end
                  end
                  CMD_INSERT: begin
                     if (printable) begin
                        if (full) begin
                           rej = 1'b1;
                        end else begin
                           ctrl.op  = OP_INSERT;
                           count_in = count_ff + CW'(1);
                           if (req_bus.move_cursor) cursor_in = cursor_ff + CW'(1);
                        end
                     end
                  end
                  CMD_APPEND: begin
                     if (printable) begin
                        if (full) begin
                           rej = 1'b1;
                        end else begin
                           ctrl.op  = OP_APPEND;
                           pos      = count_ff;
                           count_in = count_ff + CW'(1);
                           if (req_bus.move_cursor) cursor_in = count_ff + CW'(1);
                        end
                     end
                  end
                  CMD_CLEAR: begin
                     count_in  = '0;
                     cursor_in = '0;
                  end
                  CMD_READ: begin
                     load     = 1'b0;
                     ridx_in  = req_bus.read_index;
                     state_in = ST_READ_A;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ_A: state_in = ST_READ_B;
         ST_READ_B: begin
            load     = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_char_in  = (state_ff == ST_READ_B && read_hit) ? sel_char : 8'h00;
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_bus.ready);

   for (genvar i = 0; i < LINE_DEPTH; i++) begin : gen_cell
      logic [7:0] left_chr, right_chr;
      if (i == 0) begin : gen_first
         assign left_chr = 8'h00;
      end else begin : gen_mid_l
         assign left_chr = chars[i - 1];
      end
      if (i == LINE_DEPTH - 1) begin : gen_last
         assign right_chr = 8'h00;
      end else begin : gen_mid_r
         assign right_chr = chars[i + 1];
      end
      leb_cell #(
         .INDEX (i),
         .CW    (CW)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .pos       (pos),
         .chr_left  (left_chr),
         .chr_right (right_chr),
         .chr       (chars[i])
      );
   end

   leb_read_tree #(
      .RD (RD)
   ) u_read_tree (
      .clock    (clock),
      .chars    (chars[RD-1:0]),
      .idx      (ridx_ff),
      .sel_char (sel_char)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ridx_ff <= ridx_in;
      if (load) begin
         rsp_len_ff  <= 9'(count_in);
         rsp_cur_ff  <= 9'(cursor_in);
         rsp_char_ff <= rsp_char_in;
         rsp_rej_ff  <= rej;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.line_length = rsp_len_ff;
   assign rsp_bus.cursor_at   = rsp_cur_ff;
   assign rsp_bus.read_char   = rsp_char_ff;
   assign rsp_bus.rejected    = rsp_rej_ff;

   `LEB_ASSERT_ALWAYS(a_cursor_in_line, cursor_ff <= count_ff)
   `LEB_ASSERT_ALWAYS(a_count_in_depth, count_ff <= CW'(LINE_DEPTH))
   `LEB_ASSERT_NEXT(a_read_starts, req_accept && req_bus.cmd == CMD_READ, state_ff == ST_READ_A)
   `LEB_ASSERT_NEXT(a_edit_responds, req_accept && req_bus.cmd != CMD_READ, rsp_valid_ff)

endmodule
`default_nettype wire
